FILE: rtl/nhc_pkg.sv
// ----------------------------------------------------------------------------
// nhc_pkg - shared types and constants for the header check and strip block
// Result beat layout, verdict codes, config register map and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package nhc_pkg;

  // Checksum seed and header test limits
  localparam logic [7:0]  CHK_SEED     = 8'h57;
  localparam logic [7:0]  SKIP_MARK    = 8'hFF;
  localparam logic [7:0]  TS_LOW       = 8'd1;
  localparam logic [7:0]  TS_HIGH      = 8'd49;
  localparam logic [15:0] ADDR_BCAST   = 16'hFFFF;

  // Config reset values
  localparam logic [7:0]  CH_MIN_RST   = 8'd11;
  localparam logic [7:0]  CH_MAX_RST   = 8'd28;

  // Depth of the queue between the front and back halves
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_CHECKSUM = 3'd2,
    VERDICT_VERSION  = 3'd3,
    VERDICT_NETWORK  = 3'd4,
    VERDICT_CHANNEL  = 3'd5,
    VERDICT_TIMESLOT = 3'd6,
    VERDICT_NOT_ADDR = 3'd7
  } verdict_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_NET_ID      = 3'd0,
    REG_NODE_ADDR   = 3'd1,
    REG_PROTO_VER   = 3'd2,
    REG_CHANNEL_MIN = 3'd3,
    REG_CHANNEL_MAX = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  net_id;
    logic [15:0] node_address;
    logic [2:0]  protocol_version;
    logic [7:0]  channel_min;
    logic [7:0]  channel_max;
  } nhc_cfg_t;

  typedef struct packed {
    kind_t       kind;
    verdict_t    verdict;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [3:0]  packet_type;
    logic [7:0]  src_timeslot;
    logic [7:0]  src_channel;
    logic [7:0]  payload_byte;
    logic        last;
  } nhc_item_t;

endpackage

`default_nettype wire

FILE: rtl/nhc_front.sv
// ----------------------------------------------------------------------------
// nhc_front - header capture and classification
// Takes frame bytes, captures the header, judges it at the check byte and
// emits verdict and payload beats into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nhc_front
  import nhc_pkg::*;
#(
  parameter int unsigned ADDR_BYTES = 2
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire nhc_cfg_t  cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic      in_end,
  input  wire logic      queue_full,
  output logic           push,
  output nhc_item_t      push_item
);

  localparam int unsigned POS_DST = 2;
  localparam int unsigned POS_SRC = 2 + ADDR_BYTES;
  localparam int unsigned POS_TS  = 2 + 2 * ADDR_BYTES;
  localparam int unsigned POS_CH  = 3 + 2 * ADDR_BYTES;
  localparam int unsigned POS_CHK = 4 + 2 * ADDR_BYTES;
  localparam int unsigned POS_W   = $clog2(POS_CHK + 1);

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_DROP    = 2'd2
  } mode_t;

  mode_t            frame_mode;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       check_acc;
  logic [7:0]       type_byte;
  logic [7:0]       netid_seen;
  logic [15:0]      dest_seen;
  logic [15:0]      src_seen;
  logic [7:0]       ts_seen;
  logic [7:0]       ch_seen;

  logic     fire;
  logic     at_check;
  logic     skip_radio;
  verdict_t judged;

  assign in_ready = !queue_full;
  assign fire     = in_valid && in_ready;
  assign at_check = (byte_pos == POS_W'(POS_CHK));
  assign skip_radio = (ch_seen == SKIP_MARK) && (ts_seen == SKIP_MARK);

  // First failing test wins
  always_comb begin
    priority if (check_acc != in_byte) begin
      judged = VERDICT_CHECKSUM;
    end else if (type_byte[7:5] != cfg.protocol_version) begin
      judged = VERDICT_VERSION;
    end else if (netid_seen != cfg.net_id) begin
      judged = VERDICT_NETWORK;
    end else if (!skip_radio && (ch_seen < cfg.channel_min || ch_seen > cfg.channel_max)) begin
      judged = VERDICT_CHANNEL;
    end else if (!skip_radio && (ts_seen < TS_LOW || ts_seen > TS_HIGH)) begin
      judged = VERDICT_TIMESLOT;
    end else if (dest_seen != ADDR_BCAST && dest_seen != cfg.node_address) begin
      judged = VERDICT_NOT_ADDR;
    end else begin
      judged = VERDICT_ACCEPT;
    end
  end

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    push_item.last = in_end;
    unique case (frame_mode)
      MODE_FORWARD: begin
        push                   = fire;
        push_item.kind         = KIND_PAYLOAD;
        push_item.payload_byte = in_byte;
      end
      MODE_HEADER: begin
        if (at_check) begin
          push                   = fire;
          push_item.kind         = KIND_VERDICT;
          push_item.verdict      = judged;
          push_item.dest_addr    = dest_seen;
          push_item.src_addr     = src_seen;
          push_item.packet_type  = type_byte[3:0];
          push_item.src_timeslot = ts_seen;
          push_item.src_channel  = ch_seen;
        end else begin
          // frame ended inside the header
          push              = fire && in_end;
          push_item.verdict = VERDICT_SHORT;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_end)) begin
      frame_mode <= MODE_HEADER;
      byte_pos   <= '0;
      check_acc  <= CHK_SEED;
      type_byte  <= '0;
      netid_seen <= '0;
      dest_seen  <= '0;
      src_seen   <= '0;
      ts_seen    <= '0;
      ch_seen    <= '0;
    end else if (fire && frame_mode == MODE_HEADER) begin
      if (at_check) begin
        frame_mode <= (judged == VERDICT_ACCEPT) ? MODE_FORWARD : MODE_DROP;
      end else begin
        check_acc <= check_acc ^ in_byte;
        byte_pos  <= byte_pos + 1'b1;
        // only the two low address bytes are kept
        if (byte_pos == POS_W'(0))           type_byte       <= in_byte;
        if (byte_pos == POS_W'(1))           netid_seen      <= in_byte;
        if (byte_pos == POS_W'(POS_DST))     dest_seen[7:0]  <= in_byte;
        if (byte_pos == POS_W'(POS_DST + 1)) dest_seen[15:8] <= in_byte;
        if (byte_pos == POS_W'(POS_SRC))     src_seen[7:0]   <= in_byte;
        if (byte_pos == POS_W'(POS_SRC + 1)) src_seen[15:8]  <= in_byte;
        if (byte_pos == POS_W'(POS_TS))      ts_seen         <= in_byte;
        if (byte_pos == POS_W'(POS_CH))      ch_seen         <= in_byte;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nhc_queue.sv
// ----------------------------------------------------------------------------
// nhc_queue - short beat queue between front and back
// Two-entry register queue; lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module nhc_queue
  import nhc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire nhc_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output nhc_item_t      head
);

  nhc_item_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

FILE: rtl/nhc_back.sv
// ----------------------------------------------------------------------------
// nhc_back - result beat output stage
// Pulls beats from the queue into the output register and packs the bus.
// ----------------------------------------------------------------------------
`default_nettype none

module nhc_back
  import nhc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       queue_empty,
  input  wire nhc_item_t  queue_head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [63:0]     out_data,
  output logic            out_user,
  output logic            out_last
);

  nhc_item_t out_item;

  assign pop = !queue_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !queue_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= queue_head;
    end
  end

  assign out_data = {1'b0,
                     out_item.payload_byte,
                     out_item.src_channel,
                     out_item.src_timeslot,
                     out_item.packet_type,
                     out_item.src_addr,
                     out_item.dest_addr,
                     out_item.verdict};
  assign out_user = out_item.kind;
  assign out_last = out_item.last;

endmodule

`default_nettype wire

FILE: rtl/net_header_check_and_strip_top.sv
// ----------------------------------------------------------------------------
// net_header_check_and_strip_top - network header check and payload strip
// An accepted beat is written into a queue slot, then loaded into the output register that drives the master side.
// Throughput: one beat per cycle sustained while the queue is not full, limited by the single byte lane.
// A two-entry queue plus the output register absorb master-side stalls.
// Reset (rst, synchronous): config to defaults, queue empty, parser in header.
// ----------------------------------------------------------------------------
`default_nettype none

module net_header_check_and_strip_top
  import nhc_pkg::*;
#(
  parameter int unsigned ADDR_BYTES = 2   // address width in header bytes, 2..4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // frame byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast,   // frame_end
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] verdict, [18:3] dest_addr, [34:19] src_addr, [38:35] packet_type,
  // [46:39] src_timeslot, [54:47] src_channel, [62:55] payload_byte, [63] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast,   // last
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  nhc_cfg_t  cfg;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  nhc_item_t q_in;
  nhc_item_t q_head;

  // Config registers; writes always accepted, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.net_id           <= '0;
      cfg.node_address     <= '0;
      cfg.protocol_version <= '0;
      cfg.channel_min      <= CH_MIN_RST;
      cfg.channel_max      <= CH_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NET_ID:      cfg.net_id           <= cfg_data[7:0];
        REG_NODE_ADDR:   cfg.node_address     <= cfg_data;
        REG_PROTO_VER:   cfg.protocol_version <= cfg_data[2:0];
        REG_CHANNEL_MIN: cfg.channel_min      <= cfg_data[7:0];
        REG_CHANNEL_MAX: cfg.channel_max      <= cfg_data[7:0];
        default:         cfg                  <= cfg;
      endcase
    end
  end

  // Front: header capture, checksum, verdict, payload pass/drop
  nhc_front #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .queue_full (q_full),
    .push       (q_push),
    .push_item  (q_in)
  );

  // Decoupling queue
  nhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: output register and bus packing
  nhc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_empty),
    .queue_head  (q_head),
    .pop         (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_user    (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: bench/tb_net_header_check_and_strip_top.sv
// ----------------------------------------------------------------------------
// tb_net_header_check_and_strip_top - self-checking bench for header check/strip
// Feeds whole frames into the byte stream and predicts each result beat.
// A directed frame table runs first, then random frames under several config
// settings. Both stream sides idle at random, and the result side once holds
// off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_net_header_check_and_strip_top;
  import nhc_pkg::*;

  localparam int ADDR_BYTES = 2;
  localparam int HDR_LEN    = 5 + 2 * ADDR_BYTES;
  localparam int POS_DST    = 2;
  localparam int POS_SRC    = 2 + ADDR_BYTES;
  localparam int POS_TS     = 2 + 2 * ADDR_BYTES;
  localparam int POS_CH     = 3 + 2 * ADDR_BYTES;
  localparam int POS_CHK    = 4 + 2 * ADDR_BYTES;

  localparam int BEAT_TARGET = 600;        // random input beats, split over phases
  localparam int PHASES      = 5;
  localparam int DRAIN       = 6;          // cycles past the last result
  localparam int HOLD_OFF    = 80;         // long result-side stall, in cycles
  localparam int TIMEOUT     = 4_000_000;  // time units

  typedef enum logic [1:0] {
    PARSE_HEADER  = 2'd0,
    PARSE_FORWARD = 2'd1,
    PARSE_DROP    = 2'd2
  } parse_mode_t;

  // One row of the directed table: header fields, how to break the frame,
  // and the verdict where it is obvious from the row itself.
  typedef struct {
    logic [7:0]  typ;
    logic [7:0]  netid;
    logic [15:0] dest;
    logic [15:0] src;
    logic [7:0]  ts;
    logic [7:0]  ch;
    logic [7:0]  chk_err;   // XORed into the check byte
    int          cut;       // header bytes sent before frame end, 0 = full frame
    int          plen;      // payload bytes after the check byte
    bit          known;
    verdict_t    verdict;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_NET_ID;
  logic [15:0] cfg_data = '0;

  // Defaults match the block's reset config
  logic [7:0]  cfg_net  = 8'd0;
  logic [15:0] cfg_node = 16'd0;
  logic [2:0]  cfg_ver  = 3'd0;
  logic [7:0]  cfg_cmin = CH_MIN_RST;
  logic [7:0]  cfg_cmax = CH_MAX_RST;

  // Header parser copy
  parse_mode_t parse_mode;
  logic [3:0]  hdr_pos;
  logic [7:0]  chk_acc;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_netid;
  logic [15:0] hdr_dest;
  logic [15:0] hdr_src;
  logic [7:0]  hdr_ts;
  logic [7:0]  hdr_ch;

  nhc_item_t   pending_results[$];
  logic [7:0]  frame_buf[$];

  int          mismatch_count = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          payload_out = 0;
  int          frames_sent = 0;
  int          verdict_hist[8];
  int          calm_left = 0;
  bit          hold_off_req = 1'b0;
  bit          table_verdict_on = 1'b0;
  verdict_t    table_verdict = VERDICT_ACCEPT;

  // Directed frames, all under the reset config (net 0, node 0, version 0,
  // channels 11..28).
  frame_row_t directed_frames [0:18] = '{
    // good, min timeslot/channel, packet id 15, own address, src all ones
    '{8'h0F, 8'h00, 16'h0000, 16'hFFFF, 8'd1,  8'd11, 8'h00, 0, 3, 1'b1, VERDICT_ACCEPT},
    // good, max timeslot/channel, broadcast destination
    '{8'h10, 8'h00, 16'hFFFF, 16'h0000, 8'd49, 8'd28, 8'h00, 0, 2, 1'b1, VERDICT_ACCEPT},
    // frame ends on the check byte, nothing forwarded
    '{8'h05, 8'h00, 16'h0000, 16'h5AA5, 8'd20, 8'd15, 8'h00, 0, 0, 1'b1, VERDICT_ACCEPT},
    // channel and timeslot both 0xff: range tests skipped
    '{8'h03, 8'h00, 16'h0000, 16'h1234, 8'hFF, 8'hFF, 8'h00, 0, 1, 1'b1, VERDICT_ACCEPT},
    // ends after the first byte, and one byte before the check byte
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h00, 1, 0, 1'b1, VERDICT_SHORT},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h00, HDR_LEN - 1, 0, 1'b1,
      VERDICT_SHORT},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h80, 0, 2, 1'b1, VERDICT_CHECKSUM},
    '{8'hE5, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h00, 0, 2, 1'b1, VERDICT_VERSION},
    '{8'h01, 8'hFF, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h00, 0, 2, 1'b1, VERDICT_NETWORK},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd10, 8'h00, 0, 1, 1'b1, VERDICT_CHANNEL},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd29, 8'h00, 0, 1, 1'b1, VERDICT_CHANNEL},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd0,  8'd20, 8'h00, 0, 1, 1'b1, VERDICT_TIMESLOT},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd50, 8'd20, 8'h00, 0, 1, 1'b1, VERDICT_TIMESLOT},
    // only one of the pair is 0xff, so the tests still run
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'hFF, 8'd20, 8'h00, 0, 1, 1'b1, VERDICT_TIMESLOT},
    '{8'h01, 8'h00, 16'h0000, 16'h0000, 8'd5,  8'hFF, 8'h00, 0, 1, 1'b1, VERDICT_CHANNEL},
    '{8'h01, 8'h00, 16'h1234, 16'h0000, 8'd20, 8'd15, 8'h00, 0, 2, 1'b1, VERDICT_NOT_ADDR},
    // checksum wins over a bad version
    '{8'hE5, 8'h00, 16'h0000, 16'h0000, 8'd20, 8'd15, 8'h01, 0, 2, 1'b1, VERDICT_CHECKSUM},
    // left to the predictor
    '{8'h0A, 8'h00, 16'hFFFF, 16'hBEEF, 8'hFF, 8'hFF, 8'h00, 0, 4, 1'b0, VERDICT_ACCEPT},
    '{8'h2C, 8'h7E, 16'h00FF, 16'hFF00, 8'd33, 8'd12, 8'h00, 0, 3, 1'b0, VERDICT_ACCEPT}
  };

  net_header_check_and_strip_top #(
    .ADDR_BYTES(ADDR_BYTES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Header parser prediction
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    parse_mode = PARSE_HEADER;
    hdr_pos    = '0;
    chk_acc    = CHK_SEED;
    hdr_type   = '0;
    hdr_netid  = '0;
    hdr_dest   = '0;
    hdr_src    = '0;
    hdr_ts     = '0;
    hdr_ch     = '0;
  endfunction

  // First failing test wins: checksum, version, network, channel, timeslot,
  // destination.
  function automatic verdict_t header_verdict(input logic [7:0] chk);
    if (chk_acc != chk) return VERDICT_CHECKSUM;
    if (hdr_type[7:5] != cfg_ver) return VERDICT_VERSION;
    if (hdr_netid != cfg_net) return VERDICT_NETWORK;
    if (!(hdr_ch == SKIP_MARK && hdr_ts == SKIP_MARK)) begin
      if (hdr_ch < cfg_cmin || hdr_ch > cfg_cmax) return VERDICT_CHANNEL;
      if (hdr_ts < TS_LOW || hdr_ts > TS_HIGH) return VERDICT_TIMESLOT;
    end
    if (hdr_dest != ADDR_BCAST && hdr_dest != cfg_node) return VERDICT_NOT_ADDR;
    return VERDICT_ACCEPT;
  endfunction

  // Advances the parser copy by one accepted byte; returns 1 with the
  // expected result when the byte causes one.
  function automatic bit predict_byte(input logic [7:0] b, input bit fin,
                                      output nhc_item_t res);
    bit has;
    has = 1'b0;
    res = '0;
    case (parse_mode)
      PARSE_FORWARD: begin
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = b;
        res.last         = fin;
        has              = 1'b1;
      end
      PARSE_HEADER: begin
        if (hdr_pos == POS_CHK) begin
          res.kind         = KIND_VERDICT;
          res.verdict      = header_verdict(b);
          res.dest_addr    = hdr_dest;
          res.src_addr     = hdr_src;
          res.packet_type  = hdr_type[3:0];
          res.src_timeslot = hdr_ts;
          res.src_channel  = hdr_ch;
          res.last         = fin;
          has              = 1'b1;
          parse_mode = (res.verdict == VERDICT_ACCEPT) ? PARSE_FORWARD : PARSE_DROP;
        end else begin
          chk_acc ^= b;
          // address bytes above the lowest two only feed the checksum
          if (hdr_pos == 0) hdr_type = b;
          else if (hdr_pos == 1) hdr_netid = b;
          else if (hdr_pos == POS_DST) hdr_dest[7:0] = b;
          else if (hdr_pos == POS_DST + 1) hdr_dest[15:8] = b;
          else if (hdr_pos == POS_SRC) hdr_src[7:0] = b;
          else if (hdr_pos == POS_SRC + 1) hdr_src[15:8] = b;
          else if (hdr_pos == POS_TS) hdr_ts = b;
          else if (hdr_pos == POS_CH) hdr_ch = b;
          hdr_pos = hdr_pos + 4'd1;
          if (fin) begin
            res.kind    = KIND_VERDICT;
            res.verdict = VERDICT_SHORT;
            res.last    = 1'b1;
            has         = 1'b1;
          end
        end
      end
      default: ;  // rejected frame: bytes dropped
    endcase
    if (fin) clear_parser();
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Byte stream driver
  // --------------------------------------------------------------------------
  // Mostly back-to-back, some short gaps, a few long ones, and now and then a
  // calm stretch with none. No gaps while the result side is held off.
  function automatic int pick_gap();
    int r;
    if (hold_off_req) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    nhc_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    beats_in++;
    if (predict_byte(b, fin, res)) begin
      if (res.kind == KIND_VERDICT && table_verdict_on) res.verdict = table_verdict;
      pending_results.push_back(res);
    end
  endtask

  // Builds one frame (check byte computed, then spoiled by chk_err), cuts it
  // after `cut` bytes if asked, and sends it with frame end on its last beat.
  task automatic send_frame(input logic [7:0] typ, input logic [7:0] netid,
                            input logic [15:0] dest, input logic [15:0] src,
                            input logic [7:0] ts, input logic [7:0] ch,
                            input logic [7:0] chk_err, input int cut, input int plen);
    logic [7:0] acc;
    frame_buf = {};
    frame_buf.push_back(typ);
    frame_buf.push_back(netid);
    frame_buf.push_back(dest[7:0]);
    frame_buf.push_back(dest[15:8]);
    for (int i = 2; i < ADDR_BYTES; i++) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(src[7:0]);
    frame_buf.push_back(src[15:8]);
    for (int i = 2; i < ADDR_BYTES; i++) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(ts);
    frame_buf.push_back(ch);
    acc = CHK_SEED;
    foreach (frame_buf[i]) acc ^= frame_buf[i];
    frame_buf.push_back(acc ^ chk_err);
    for (int i = 0; i < plen; i++) frame_buf.push_back(8'($urandom));
    if (cut > 0) while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Mostly well-formed frames that pass under the current config, with random
  // content; the rest break one test, end early, or are plain noise.
  task automatic send_random_frame();
    logic [7:0]  typ, netid, ts, ch, chk_err;
    logic [15:0] dest, src;
    int          cut, plen;
    typ     = {cfg_ver, 5'($urandom)};
    netid   = cfg_net;
    dest    = ($urandom_range(0, 3) == 0) ? ADDR_BCAST : cfg_node;
    src     = 16'($urandom);
    chk_err = 8'h00;
    cut     = 0;
    plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    if (cfg_cmin <= cfg_cmax && $urandom_range(0, 9) != 0) begin
      ch = 8'($urandom_range(cfg_cmax, cfg_cmin));
      ts = 8'($urandom_range(TS_HIGH, TS_LOW));
    end else begin
      ch = SKIP_MARK;
      ts = SKIP_MARK;
    end
    case ($urandom_range(0, 19))
      0: chk_err = 8'($urandom_range(1, 255));
      1: typ[7:5] ^= 3'($urandom_range(1, 7));
      2: netid ^= 8'($urandom_range(1, 255));
      3: ch = 8'($urandom);
      4: ts = 8'($urandom);
      5: dest = 16'($urandom);
      6, 7: cut = $urandom_range(1, HDR_LEN - 1);
      8: begin
        typ     = 8'($urandom);
        netid   = 8'($urandom);
        dest    = 16'($urandom);
        ts      = 8'($urandom);
        ch      = 8'($urandom);
        chk_err = 8'($urandom);
      end
      default: ;
    endcase
    send_frame(typ, netid, dest, src, ts, ch, chk_err, cut, plen);
  endtask

  // Stop offering, let every expected result out, then cover the bytes in
  // flight that cause no result.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Config writes (only while idle)
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NET_ID:      cfg_net  = val[7:0];
      REG_NODE_ADDR:   cfg_node = val;
      REG_PROTO_VER:   cfg_ver  = val[2:0];
      REG_CHANNEL_MIN: cfg_cmin = val[7:0];
      REG_CHANNEL_MAX: cfg_cmax = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] net, input logic [15:0] node,
                              input logic [2:0] ver, input logic [7:0] cmin,
                              input logic [7:0] cmax);
    wait_idle();
    write_reg(REG_NET_ID, {8'h00, net});
    write_reg(REG_NODE_ADDR, node);
    write_reg(REG_PROTO_VER, {13'h0000, ver});
    write_reg(REG_CHANNEL_MIN, {8'h00, cmin});
    write_reg(REG_CHANNEL_MAX, {8'h00, cmax});
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_ready_drive
    int r, n;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 50) ? $urandom_range(1, 20) :
            (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        @(negedge clk);
        m_axis_tready <= (r < 50);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking, one field at a time against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    nhc_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tuser %0b tdata 0x%0h",
               m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.kind == KIND_PAYLOAD) payload_out++;
        else verdict_hist[want.verdict]++;
        check_field("kind",         16'(want.kind),         16'(m_axis_tuser));
        check_field("verdict",      16'(want.verdict),      16'(m_axis_tdata[2:0]));
        check_field("dest_addr",    want.dest_addr,         m_axis_tdata[18:3]);
        check_field("src_addr",     want.src_addr,          m_axis_tdata[34:19]);
        check_field("packet_type",  16'(want.packet_type),  16'(m_axis_tdata[38:35]));
        check_field("src_timeslot", 16'(want.src_timeslot), 16'(m_axis_tdata[46:39]));
        check_field("src_channel",  16'(want.src_channel),  16'(m_axis_tdata[54:47]));
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_axis_tdata[62:55]));
        check_field("last",         16'(want.last),         16'(m_axis_tlast));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin : run
    int phase_start;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames under the reset config
    foreach (directed_frames[i]) begin
      table_verdict_on = directed_frames[i].known;
      table_verdict    = directed_frames[i].verdict;
      send_frame(directed_frames[i].typ, directed_frames[i].netid,
                 directed_frames[i].dest, directed_frames[i].src,
                 directed_frames[i].ts, directed_frames[i].ch,
                 directed_frames[i].chk_err, directed_frames[i].cut,
                 directed_frames[i].plen);
    end
    table_verdict_on = 1'b0;

    // random phases: typical, all-low, all-high, crossed channel limits,
    // typical again with the long result-side hold-off
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       apply_config(8'h00, 16'h0000, 3'd0, 8'd0, 8'd0);
        2:       apply_config(8'hFF, 16'hFFFF, 3'd7, 8'd255, 8'd255);
        3:       apply_config(8'($urandom), 16'($urandom), 3'($urandom), 8'd200, 8'd100);
        default: apply_config(8'($urandom), 16'($urandom), 3'($urandom),
                              8'($urandom_range(0, 120)), 8'($urandom_range(121, 255)));
      endcase
      if (p == PHASES - 1) hold_off_req = 1'b1;
      phase_start = beats_in;
      while (beats_in - phase_start < BEAT_TARGET / PHASES) send_random_frame();
    end

    wait_idle();
    $display("Ran %0d frames: %0d input beats, %0d result beats (%0d payload)",
             frames_sent, beats_in, beats_out, payload_out);
    $display("Verdict counts by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             verdict_hist[VERDICT_ACCEPT], verdict_hist[VERDICT_SHORT],
             verdict_hist[VERDICT_CHECKSUM], verdict_hist[VERDICT_VERSION],
             verdict_hist[VERDICT_NETWORK], verdict_hist[VERDICT_CHANNEL],
             verdict_hist[VERDICT_TIMESLOT], verdict_hist[VERDICT_NOT_ADDR]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
